FILE: design/hof_pkg.sv
// shared constants, types and helpers of the hampel outlier filter
package hof_pkg;

  // window geometry
  localparam int Window   = 5;
  localparam int MidIdx   = Window / 2;
  localparam int FillNeed = Window - Window / 2;
  localparam int IdxW     = $clog2(Window);
  localparam int FillW    = $clog2(FillNeed + 1);

  // data widths
  localparam int SampleW  = 16;
  localparam int DevW     = 16;
  localparam int ValW     = 17;
  localparam int ThrW     = 12;
  localparam int KappaW   = 16;
  localparam int ProdW    = ThrW + KappaW;
  localparam int RhsW     = ProdW + DevW;
  localparam int LhsShift = 23;

  // kappa = 1.4826 in Q1.15, threshold reset = 1.0 in Q4.8
  localparam logic [KappaW-1:0] KappaQ15 = 16'd48582;
  localparam logic [ThrW-1:0]   ThrReset = 12'd256;

  typedef logic signed [SampleW-1:0] sample_t;
  typedef logic signed [ValW-1:0]    sel_val_t;
  typedef sel_val_t                  sel_arr_t [Window];

  // magnitude of the difference of two samples
  function automatic logic [DevW-1:0] abs_diff(input sample_t a, input sample_t b);
    logic signed [SampleW:0] diff;
    diff = {a[SampleW-1], a} - {b[SampleW-1], b};
    abs_diff = diff[SampleW] ? DevW'(-diff) : DevW'(diff);
  endfunction

endpackage

FILE: design/hof_select.sv
// iterative rank selector: finds the middle-ranked value with one comparator
module hof_select import hof_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  sel_arr_t vals_i,
  output logic     done_o,
  output sel_val_t med_o
);

  sel_arr_t          rot_q;
  sel_val_t          cand_q;
  sel_val_t          med_q;
  logic              active_q;
  logic              done_q;
  logic [IdxW-1:0]   c_q;
  logic [IdxW-1:0]   j_q;
  logic [IdxW-1:0]   rank_q;

  logic              first;
  logic              last;
  logic              late;
  logic              hit;
  logic [IdxW-1:0]   rank_inc;
  logic              found;

  // shared compare unit, ties broken by original position
  assign first    = (j_q == '0);
  assign last     = (j_q == IdxW'(Window - 1));
  assign late     = (({1'b0, c_q} + {1'b0, j_q}) >= (IdxW + 1)'(Window));
  assign hit      = (rot_q[0] < cand_q) || ((rot_q[0] == cand_q) && late);
  assign rank_inc = rank_q + IdxW'(hit);
  assign found    = (rank_inc == IdxW'(MidIdx));

  // rotating value store, candidate and result
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rot_q <= vals_i;
    end else if (active_q) begin
      for (int i = 0; i < Window; i++) begin
        if (last) begin
          rot_q[i] <= rot_q[(i + 2) % Window];
        end else begin
          rot_q[i] <= rot_q[(i + 1) % Window];
        end
      end
    end
    if (active_q && first) begin
      cand_q <= rot_q[0];
    end
    if (active_q && last && found) begin
      med_q <= cand_q;
    end
  end

  // pass and step sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      c_q      <= '0;
      j_q      <= '0;
      rank_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        active_q <= 1'b1;
        c_q      <= '0;
        j_q      <= '0;
        rank_q   <= '0;
      end else if (active_q) begin
        if (first) begin
          j_q    <= IdxW'(1);
          rank_q <= '0;
        end else if (last) begin
          if (found) begin
            active_q <= 1'b0;
            done_q   <= 1'b1;
          end else begin
            c_q <= c_q + IdxW'(1);
            j_q <= '0;
          end
        end else begin
          j_q    <= j_q + IdxW'(1);
          rank_q <= rank_inc;
        end
      end
    end
  end

  assign done_o = done_q;
  assign med_o  = med_q;

endmodule

FILE: design/hof_test.sv
// outlier test: two products on one shared multiplier, then an exact compare
module hof_test import hof_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [DevW-1:0] adiff_i,
  input  logic [DevW-1:0] dev_i,
  input  logic [ThrW-1:0] thr_i,
  output logic            done_o,
  output logic            outlier_o
);

  typedef enum logic [1:0] {
    T_IDLE,
    T_MUL1,
    T_MUL2,
    T_CMP
  } tst_state_e;

  tst_state_e        state_q;
  logic              done_q;
  logic              outlier_q;
  logic [DevW-1:0]   adiff_q;
  logic [DevW-1:0]   dev_q;
  logic [ThrW-1:0]   thr_q;
  logic [RhsW-1:0]   mul_q;

  logic [ProdW-1:0]  mul_a;
  logic [DevW-1:0]   mul_b;
  logic [RhsW-1:0]   mul_p;
  logic [RhsW-1:0]   lhs;

  // operand select: threshold * kappa first, then that product * deviation
  always_comb begin
    if (state_q == T_MUL1) begin
      mul_a = ProdW'(thr_q);
      mul_b = DevW'(KappaQ15);
    end else begin
      mul_a = mul_q[ProdW-1:0];
      mul_b = dev_q;
    end
  end

  assign mul_p = RhsW'(mul_a) * RhsW'(mul_b);
  assign lhs   = RhsW'({adiff_q, {LhsShift{1'b0}}});

  // operand capture and product register
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      adiff_q <= adiff_i;
      dev_q   <= dev_i;
      thr_q   <= thr_i;
    end
    if (state_q == T_MUL1 || state_q == T_MUL2) begin
      mul_q <= mul_p;
    end
  end

  // step sequencer with registered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= T_IDLE;
      done_q    <= 1'b0;
      outlier_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        T_IDLE: begin
          if (start_i) begin
            state_q <= T_MUL1;
          end
        end
        T_MUL1: begin
          state_q <= T_MUL2;
        end
        T_MUL2: begin
          state_q <= T_CMP;
        end
        T_CMP: begin
          outlier_q <= (lhs >= mul_q);
          done_q    <= 1'b1;
          state_q   <= T_IDLE;
        end
        default: begin
          state_q <= T_IDLE;
        end
      endcase
    end
  end

  assign done_o    = done_q;
  assign outlier_o = outlier_q;

endmodule

FILE: design/hampel_outlier_filter.sv
// top level of the hampel outlier filter: window, sequencer and output register
//
// channel   direction  signals                              transaction when
// in        input      in_valid_i, in_stall_o, sample_i     in_valid_i and not in_stall_o
// out       output     out_valid_o, out_stall_i, filtered_o out_valid_o and not out_stall_i
//                      replaced_o
// cfg       input      cfg_we_i, cfg_wdata_i                cfg_we_i
//
// a sample that yields a result takes two rank selections of one to Window passes
// (one compare per cycle), the multiply and compare of the outlier test, and the load
// of the output register that raises out_valid_o; the next sample can then be taken
// in_stall_o is high from the transaction of such a sample until the result is loaded; a result
// held by out_stall_i does not block the next sample, only the next load
// reset clears the window and fill count and sets the threshold to 1.0 at once; no clearing pass
module hampel_outlier_filter import hof_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic signed [15:0]  sample_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [15:0]  filtered_o,
  output logic                replaced_o,
  input  logic                cfg_we_i,
  input  logic [11:0]         cfg_wdata_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MED,
    S_DEV,
    S_TEST,
    S_PUSH
  } top_state_e;

  top_state_e        state_q;
  sample_t           win_q [Window];
  logic [FillW-1:0]  fill_q;
  logic [ThrW-1:0]   thr_q;
  sel_val_t          med_q;
  logic              out_valid_q;
  sample_t           filtered_q;
  logic              replaced_q;

  sample_t           win_next [Window];
  logic [FillW-1:0]  fill_next;
  logic              in_take;
  sel_arr_t          sel_vals;
  logic              sel_start;
  logic              sel_done;
  sel_val_t          sel_med;
  logic              tst_start;
  logic              tst_done;
  logic              tst_outlier;
  logic [DevW-1:0]   mid_adiff;
  logic              out_free;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_take    = in_valid_i && (state_q == S_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;

  // window after the incoming sample is shifted in
  always_comb begin
    for (int i = 0; i < Window - 1; i++) begin
      win_next[i] = win_q[i + 1];
    end
    win_next[Window - 1] = sample_i;
    fill_next = (fill_q == FillW'(FillNeed)) ? fill_q : fill_q + FillW'(1);
  end

  // selector operands: window samples for the median, deviations for the mad
  always_comb begin
    for (int i = 0; i < Window; i++) begin
      if (state_q == S_IDLE) begin
        sel_vals[i] = ValW'(win_next[i]);
      end else begin
        sel_vals[i] = sel_val_t'({1'b0, abs_diff(win_q[i], sample_t'(sel_med))});
      end
    end
  end

  assign sel_start = (in_take && (fill_next == FillW'(FillNeed)))
                   || ((state_q == S_MED) && sel_done);
  assign mid_adiff = abs_diff(win_q[MidIdx], sample_t'(med_q));
  assign tst_start = (state_q == S_DEV) && sel_done;

  hof_select u_select (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sel_start),
    .vals_i  (sel_vals),
    .done_o  (sel_done),
    .med_o   (sel_med)
  );

  hof_test u_test (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (tst_start),
    .adiff_i   (mid_adiff),
    .dev_i     (sel_med[DevW-1:0]),
    .thr_i     (thr_q),
    .done_o    (tst_done),
    .outlier_o (tst_outlier)
  );

  // median capture and output payload
  always_ff @(posedge clk_i) begin
    if ((state_q == S_MED) && sel_done) begin
      med_q <= sel_med;
    end
    if ((state_q == S_PUSH) && out_free) begin
      filtered_q <= tst_outlier ? sample_t'(med_q) : win_q[MidIdx];
      replaced_q <= tst_outlier;
    end
  end

  // sequencer, window store, threshold and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      thr_q       <= ThrReset;
      out_valid_q <= 1'b0;
      for (int i = 0; i < Window; i++) begin
        win_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_take) begin
            win_q  <= win_next;
            fill_q <= fill_next;
            if (fill_next == FillW'(FillNeed)) begin
              state_q <= S_MED;
            end
          end
        end
        S_MED: begin
          if (sel_done) begin
            state_q <= S_DEV;
          end
        end
        S_DEV: begin
          if (sel_done) begin
            state_q <= S_TEST;
          end
        end
        S_TEST: begin
          if (tst_done) begin
            state_q <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign filtered_o  = filtered_q;
  assign replaced_o  = replaced_q;

endmodule
